>>> sv/golden_section_extremum_search_defines.svh
// Assertion macros for the golden-section search block.
// Used by the port checker; expects clk_i and rst_ni in the including scope.
`ifndef GOLDEN_SECTION_EXTREMUM_SEARCH_DEFINES_SVH
`define GOLDEN_SECTION_EXTREMUM_SEARCH_DEFINES_SVH

// same-cycle implication, quiet during reset
`define GSE_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gse: same-cycle check failed");

// next-cycle implication, quiet during reset
`define GSE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gse: next-cycle check failed");

`endif

>>> sv/gse_pkg.sv
// Shared types, constants and microcode ROM for the golden-section search block.
// No dependencies; imported by every other module.
package gse_pkg;

  localparam int unsigned MAX_ITER_DEFAULT  = 64;
  localparam int unsigned FRAC_BITS_DEFAULT = 16;
  localparam logic [30:0] TOL_RESET         = 31'd66;
  localparam int unsigned APB_AW            = 4;
  localparam int unsigned UPC_W             = 5;

  // microcode entry points
  localparam logic [UPC_W-1:0] UA_IDLE = 5'd0;
  localparam logic [UPC_W-1:0] UA_LOOP = 5'd11;
  localparam logic [UPC_W-1:0] UA_MID  = 5'd18;

  // register index, byte address is 4 * index
  typedef enum logic [1:0] {
    REG_TOLERANCE = 2'd0,
    REG_SEEK_MAX  = 2'd1,
    REG_FUNC_SEL  = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    OP_NOP   = 4'd0,
    OP_LOAD  = 4'd1,
    OP_WIDTH = 4'd2,
    OP_MULW  = 4'd3,
    OP_MULSQ = 4'd4,
    OP_ROUND = 4'd5,
    OP_XINIT = 4'd6,
    OP_XNEW  = 4'd7,
    OP_FWR   = 4'd8,
    OP_CMP   = 4'd9,
    OP_MID   = 4'd10,
    OP_FOUT  = 4'd11
  } dp_op_e;

  typedef enum logic [1:0] {
    XS_X1   = 2'd0,
    XS_X2   = 2'd1,
    XS_SIDE = 2'd2,
    XS_MID  = 2'd3
  } xsel_e;

  typedef enum logic [1:0] {
    FS_F1   = 2'd0,
    FS_F2   = 2'd1,
    FS_SIDE = 2'd2
  } fsel_e;

  typedef enum logic [2:0] {
    SEQ_NEXT     = 3'd0,
    SEQ_JUMP     = 3'd1,
    SEQ_WAIT_IN  = 3'd2,
    SEQ_WAIT_OUT = 3'd3,
    SEQ_EXIT     = 3'd4
  } seq_e;

  typedef struct packed {
    dp_op_e           op;
    xsel_e            xsel;
    fsel_e            fsel;
    seq_e             seq;
    logic [UPC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic [30:0] tolerance;
    logic        seek_maximum;
    logic        function_select;
  } cfg_t;

  typedef struct packed {
    logic done;      // width within tolerance or count at cap
    logic out_busy;  // result register full and stalled
  } dp_flags_t;

  // round(0.6180339887 * 2^fb), from the 32-bit golden fraction
  function automatic logic [31:0] golden_frac(input int unsigned fb);
    logic [63:0] g;
    g = (64'd2654435769 + (64'd1 << (31 - fb))) >> (32 - fb);
    return g[31:0];
  endfunction

  function automatic ucode_t mk(input dp_op_e op, input xsel_e xs, input fsel_e fs,
                                input seq_e sq, input logic [UPC_W-1:0] tgt);
    ucode_t w;
    w.op     = op;
    w.xsel   = xs;
    w.fsel   = fs;
    w.seq    = sq;
    w.target = tgt;
    return w;
  endfunction

  // Program: set up x1/x2 and f1/f2, then one narrowing iteration per pass of
  // steps 11..17, leaving at step 12 once the width test passes or the count
  // reaches the cap.
  function automatic ucode_t ucode_word(input logic [UPC_W-1:0] addr);
    ucode_t w;
    unique case (addr)
      5'd0:    w = mk(OP_LOAD,  XS_X1,   FS_F1,   SEQ_WAIT_IN,  UA_IDLE);
      5'd1:    w = mk(OP_WIDTH, XS_X1,   FS_F1,   SEQ_NEXT,     UA_IDLE);
      5'd2:    w = mk(OP_MULW,  XS_X1,   FS_F1,   SEQ_NEXT,     UA_IDLE);
      5'd3:    w = mk(OP_ROUND, XS_X1,   FS_F1,   SEQ_NEXT,     UA_IDLE);
      5'd4:    w = mk(OP_XINIT, XS_X1,   FS_F1,   SEQ_NEXT,     UA_IDLE);
      5'd5:    w = mk(OP_MULSQ, XS_X1,   FS_F1,   SEQ_NEXT,     UA_IDLE);
      5'd6:    w = mk(OP_ROUND, XS_X1,   FS_F1,   SEQ_NEXT,     UA_IDLE);
      5'd7:    w = mk(OP_FWR,   XS_X1,   FS_F1,   SEQ_NEXT,     UA_IDLE);
      5'd8:    w = mk(OP_MULSQ, XS_X2,   FS_F1,   SEQ_NEXT,     UA_IDLE);
      5'd9:    w = mk(OP_ROUND, XS_X2,   FS_F1,   SEQ_NEXT,     UA_IDLE);
      5'd10:   w = mk(OP_FWR,   XS_X2,   FS_F2,   SEQ_NEXT,     UA_IDLE);
      5'd11:   w = mk(OP_CMP,   XS_X1,   FS_F1,   SEQ_NEXT,     UA_IDLE);
      5'd12:   w = mk(OP_MULW,  XS_X1,   FS_F1,   SEQ_EXIT,     UA_MID);
      5'd13:   w = mk(OP_ROUND, XS_X1,   FS_F1,   SEQ_NEXT,     UA_IDLE);
      5'd14:   w = mk(OP_XNEW,  XS_X1,   FS_F1,   SEQ_NEXT,     UA_IDLE);
      5'd15:   w = mk(OP_MULSQ, XS_SIDE, FS_F1,   SEQ_NEXT,     UA_IDLE);
      5'd16:   w = mk(OP_ROUND, XS_SIDE, FS_F1,   SEQ_NEXT,     UA_IDLE);
      5'd17:   w = mk(OP_FWR,   XS_SIDE, FS_SIDE, SEQ_JUMP,     UA_LOOP);
      5'd18:   w = mk(OP_MID,   XS_MID,  FS_F1,   SEQ_NEXT,     UA_IDLE);
      5'd19:   w = mk(OP_MULSQ, XS_MID,  FS_F1,   SEQ_NEXT,     UA_IDLE);
      5'd20:   w = mk(OP_ROUND, XS_MID,  FS_F1,   SEQ_NEXT,     UA_IDLE);
      5'd21:   w = mk(OP_FOUT,  XS_MID,  FS_F1,   SEQ_WAIT_OUT, UA_IDLE);
      default: w = mk(OP_NOP,   XS_X1,   FS_F1,   SEQ_JUMP,     UA_IDLE);
    endcase
    return w;
  endfunction

endpackage

>>> sv/golden_section_extremum_search.sv
// Golden-section search for the minimum or maximum of 10x+2x^2 or 10x-2x^2
// over a signed Q16.16 interval (bounds swapped if reversed). One result per
// transaction: midpoint, function value there (Q48.16), iteration count and a
// cap flag. A microcoded sequencer drives one shared 33x33 multiplier and its
// rounding stage; each narrowing iteration passes through that multiplier
// twice. A finished result waits at the last step while the previous one is
// still held stalled in the output register. A new input is taken while the
// previous result still waits in the output register.
// Depends on gse_pkg, gse_cfg, gse_seq and gse_dp.
module golden_section_extremum_search import gse_pkg::*; #(
  parameter int unsigned MAX_ITERATIONS = MAX_ITER_DEFAULT,
  parameter int unsigned FRACTION_BITS  = FRAC_BITS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] lower_bound_i,
  input  logic signed [31:0] upper_bound_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] best_position_o,
  output logic signed [63:0] best_value_o,
  output logic [6:0]         iteration_count_o,
  output logic               status_o
);

  cfg_t      cfg;
  ucode_t    ctrl;
  dp_flags_t flags;
  logic      in_fire;

  assign in_stall_o = (ctrl.seq != SEQ_WAIT_IN);

  gse_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gse_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .flags_i    (flags),
    .ctrl_o     (ctrl),
    .in_fire_o  (in_fire)
  );

  gse_dp #(
    .MAX_ITERATIONS (MAX_ITERATIONS),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .cfg_i             (cfg),
    .in_fire_i         (in_fire),
    .lower_bound_i     (lower_bound_i),
    .upper_bound_i     (upper_bound_i),
    .out_stall_i       (out_stall_i),
    .flags_o           (flags),
    .out_valid_o       (out_valid_o),
    .best_position_o   (best_position_o),
    .best_value_o      (best_value_o),
    .iteration_count_o (iteration_count_o),
    .status_o          (status_o)
  );

endmodule

>>> sv/gse_cfg.sv
// APB-style register file: tolerance, seek_maximum, function_select.
// Depends on gse_pkg for cfg_t, register indexes and reset values.
module gse_cfg import gse_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tolerance       <= TOL_RESET;
      cfg_q.seek_maximum    <= 1'b0;
      cfg_q.function_select <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_TOLERANCE: cfg_q.tolerance       <= pwdata[30:0];
        REG_SEEK_MAX:  cfg_q.seek_maximum    <= pwdata[0];
        REG_FUNC_SEL:  cfg_q.function_select <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TOLERANCE: prdata = {1'b0, cfg_q.tolerance};
      REG_SEEK_MAX:  prdata = {31'd0, cfg_q.seek_maximum};
      REG_FUNC_SEL:  prdata = {31'd0, cfg_q.function_select};
      default:       prdata = '0;
    endcase
  end

endmodule

>>> sv/gse_seq.sv
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
// Depends on gse_pkg for the ROM and control word types.
module gse_seq import gse_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  dp_flags_t flags_i,
  output ucode_t    ctrl_o,
  output logic      in_fire_o
);

  logic [UPC_W-1:0] upc_q, upc_d;
  ucode_t           ctrl;

  assign ctrl      = ucode_word(upc_q);
  assign ctrl_o    = ctrl;
  assign in_fire_o = in_valid_i && (ctrl.seq == SEQ_WAIT_IN);

  always_comb begin
    unique case (ctrl.seq)
      SEQ_NEXT:     upc_d = upc_q + UPC_W'(1);
      SEQ_JUMP:     upc_d = ctrl.target;
      SEQ_WAIT_IN:  upc_d = in_fire_o ? upc_q + UPC_W'(1) : upc_q;
      SEQ_WAIT_OUT: upc_d = flags_i.out_busy ? upc_q : ctrl.target;
      SEQ_EXIT:     upc_d = flags_i.done ? ctrl.target : upc_q + UPC_W'(1);
      default:      upc_d = UA_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UA_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

>>> sv/gse_dp.sv
// Datapath: interval registers, shared 33x33 multiplier, rounding stage,
// objective adder, compare and the result register. Depends on gse_pkg.
module gse_dp import gse_pkg::*; #(
  parameter int unsigned MAX_ITERATIONS = MAX_ITER_DEFAULT,
  parameter int unsigned FRACTION_BITS  = FRAC_BITS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ucode_t             ctrl_i,
  input  cfg_t               cfg_i,
  input  logic               in_fire_i,
  input  logic signed [31:0] lower_bound_i,
  input  logic signed [31:0] upper_bound_i,
  input  logic               out_stall_i,
  output dp_flags_t          flags_o,
  output logic               out_valid_o,
  output logic signed [31:0] best_position_o,
  output logic signed [63:0] best_value_o,
  output logic [6:0]         iteration_count_o,
  output logic               status_o
);

  localparam int unsigned     CntW       = $clog2(MAX_ITERATIONS + 1);
  localparam logic [CntW-1:0] CntMax     = CntW'(MAX_ITERATIONS);
  localparam logic [31:0]     GoldenFrac = golden_frac(FRACTION_BITS);
  localparam logic [63:0]     HalfLsb    = 64'd1 << (FRACTION_BITS - 1);

  logic signed [31:0] a_q, b_q, x1_q, x2_q, mid_q;
  logic [31:0]        w_q;
  logic [63:0]        prod_q, rnd_q;
  logic signed [63:0] lin_q, f1_q, f2_q;
  logic               left_q;
  logic [CntW-1:0]    cnt_q;
  logic               status_q;

  logic signed [31:0] pos_q;
  logic signed [63:0] val_q;
  logic [6:0]         cnt_out_q;
  logic               stat_out_q;
  logic               out_valid_q;

  logic signed [31:0] eval_x;
  logic signed [32:0] mul_a_d, mul_b_d;
  logic signed [65:0] prod_full;
  logic [63:0]        prod_d;
  logic signed [63:0] x64, lin_d, quad, f_new;
  logic [31:0]        step;
  logic               left_wins, tol_hit, out_busy, fout_fire;

  always_comb begin
    unique case (ctrl_i.xsel)
      XS_X1:   eval_x = x1_q;
      XS_X2:   eval_x = x2_q;
      XS_SIDE: eval_x = left_q ? x1_q : x2_q;
      XS_MID:  eval_x = mid_q;
      default: eval_x = x1_q;
    endcase
  end

  // square taken signed: x*x equals |x|^2
  always_comb begin
    if (ctrl_i.op == OP_MULW) begin
      mul_a_d = {1'b0, w_q};
      mul_b_d = {1'b0, GoldenFrac};
    end else begin
      mul_a_d = {eval_x[31], eval_x};
      mul_b_d = {eval_x[31], eval_x};
    end
  end

  assign prod_full = mul_a_d * mul_b_d;
  assign prod_d    = prod_full[63:0];

  assign x64   = {{32{eval_x[31]}}, eval_x};
  assign lin_d = (x64 <<< 3) + (x64 <<< 1);

  assign step  = rnd_q[31:0];
  assign quad  = {rnd_q[62:0], 1'b0};
  assign f_new = cfg_i.function_select ? lin_q - quad : lin_q + quad;

  // tie keeps the right part
  assign left_wins = cfg_i.seek_maximum ? (f1_q > f2_q) : (f1_q < f2_q);
  assign tol_hit   = w_q <= {1'b0, cfg_i.tolerance};

  assign out_busy  = out_valid_q && out_stall_i;
  assign fout_fire = (ctrl_i.op == OP_FOUT) && !out_busy;

  assign flags_o.done     = tol_hit || (cnt_q >= CntMax);
  assign flags_o.out_busy = out_busy;

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      OP_LOAD: begin
        if (in_fire_i) begin
          if (lower_bound_i > upper_bound_i) begin
            a_q <= upper_bound_i;
            b_q <= lower_bound_i;
          end else begin
            a_q <= lower_bound_i;
            b_q <= upper_bound_i;
          end
          cnt_q <= '0;
        end
      end
      OP_WIDTH: w_q <= 32'(b_q - a_q);
      OP_MULW: begin
        prod_q   <= prod_d;
        status_q <= !tol_hit;
      end
      OP_MULSQ: begin
        prod_q <= prod_d;
        lin_q  <= lin_d;
      end
      OP_ROUND: rnd_q <= (prod_q + HalfLsb) >> FRACTION_BITS;
      OP_XINIT: begin
        x1_q <= 32'(b_q - step);
        x2_q <= 32'(a_q + step);
      end
      OP_XNEW: begin
        if (left_q) begin
          x1_q <= 32'(b_q - step);
        end else begin
          x2_q <= 32'(a_q + step);
        end
      end
      OP_FWR: begin
        unique case (ctrl_i.fsel)
          FS_F1: f1_q <= f_new;
          FS_F2: f2_q <= f_new;
          FS_SIDE: begin
            if (left_q) begin
              f1_q <= f_new;
            end else begin
              f2_q <= f_new;
            end
          end
          default: ;
        endcase
      end
      OP_CMP: begin
        left_q <= left_wins;
        cnt_q  <= cnt_q + CntW'(1);
        if (left_wins) begin
          b_q  <= x2_q;
          x2_q <= x1_q;
          f2_q <= f1_q;
          w_q  <= 32'(x2_q - a_q);
        end else begin
          a_q  <= x1_q;
          x1_q <= x2_q;
          f1_q <= f2_q;
          w_q  <= 32'(b_q - x1_q);
        end
      end
      OP_MID: mid_q <= 32'(a_q + (w_q >> 1));
      OP_FOUT: begin
        if (fout_fire) begin
          pos_q      <= mid_q;
          val_q      <= f_new;
          cnt_out_q  <= 7'(cnt_q);
          stat_out_q <= status_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fout_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign best_position_o   = pos_q;
  assign best_value_o      = val_q;
  assign iteration_count_o = cnt_out_q;
  assign status_o          = stat_out_q;

endmodule

>>> sv/gse_checker.sv
// Port-level checker for the golden-section search block, bound to the top level.
// Depends on gse_pkg and the assertion macro header.
`include "golden_section_extremum_search_defines.svh"

module gse_checker import gse_pkg::*; #(
  parameter int unsigned MAX_ITERATIONS = MAX_ITER_DEFAULT
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] best_position_o,
  input logic signed [63:0] best_value_o,
  input logic [6:0]         iteration_count_o,
  input logic               status_o
);

  // result held while stalled
  `GSE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `GSE_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(best_value_o) && $stable(best_position_o))
  // no new input is taken in the cycle after one was accepted
  `GSE_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  // cap flag only with a full count
  `GSE_ASSERT_IMPL(a_cap_count, out_valid_o && status_o, iteration_count_o == 7'(MAX_ITERATIONS))

endmodule

bind golden_section_extremum_search gse_checker #(
  .MAX_ITERATIONS (MAX_ITERATIONS)
) u_gse_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .best_position_o   (best_position_o),
  .best_value_o      (best_value_o),
  .iteration_count_o (iteration_count_o),
  .status_o          (status_o)
);
